/* rtl/core/wacmt_pkg.sv */
// Shared types and constants for the wing angle correction and motion tracking core.
// Used by every module in rtl/core; depends on nothing else.
package wacmt_pkg;

	// Field widths
	localparam int BEARING_W = 9;
	localparam int OFFSET_W  = 9;
	localparam int ERROR_W   = 8;
	localparam int ANGLE_W   = 9;
	localparam int DEV_W     = 8;
	localparam int MOVE_W    = 11;
	localparam int RAW_W     = 11;
	localparam int PROD_W    = 17;
	localparam int MAG_W     = 15;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_0    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_90   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_180  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_270  = 3'd4;

	// Input modes
	localparam logic MODE_ANGLE  = 1'b0;
	localparam logic MODE_HEALTH = 1'b1;

	// Division by 90 as a multiply by ceil(2^21 / 90) and a shift; exact for
	// magnitudes below 2^21 / 28, well above the largest interpolation product.
	localparam int               RECIP_SHIFT = 21;
	localparam logic [MAG_W-1:0] RECIP_90    = 15'd23302;

	// Stream widths
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 32;

	// Calibration registers
	typedef struct packed {
		logic signed [OFFSET_W-1:0] offset;
		logic signed [ERROR_W-1:0]  e0;
		logic signed [ERROR_W-1:0]  e90;
		logic signed [ERROR_W-1:0]  e180;
		logic signed [ERROR_W-1:0]  e270;
	} wacmt_cfg_t;

	// Interpolation stage payload
	typedef struct packed {
		logic                      mode;
		logic signed [RAW_W-1:0]   raw;
		logic signed [PROD_W-1:0]  prod;
		logic signed [ERROR_W-1:0] base;
	} wacmt_s2_t;

	// Corrected angle stage payload
	typedef struct packed {
		logic                      mode;
		logic signed [ANGLE_W-1:0] angle;
		logic signed [DEV_W-1:0]   dev;
	} wacmt_s3_t;

endpackage

/* rtl/core/wacmt_interp.sv */
// Interpolation front end: offset addition, segment choice and the product term.
// Depends on wacmt_pkg.
module wacmt_interp
	import wacmt_pkg::*;
(
	input  logic                        clk,
	input  logic                        load,
	input  logic                        mode,
	input  logic signed [BEARING_W-1:0] bearing,
	input  wacmt_cfg_t                  cfg,
	output wacmt_s2_t                   s2
);

	logic signed [RAW_W-1:0]   raw;
	logic [6:0]                t;
	logic signed [ERROR_W:0]   d;
	logic signed [ERROR_W-1:0] base;
	logic signed [RAW_W-1:0]   t_full;
	logic signed [7:0]         t_ext;
	logic signed [PROD_W-1:0]  prod;

	// Raw bearing at full width.
	assign raw = RAW_W'(bearing) + RAW_W'(cfg.offset);

	// Pick the quadrant, the distance from its start, the error slope and its base.
	always_comb begin
		t_full = '0;
		d      = '0;
		base   = '0;
		if (raw >= 0 && raw < 11'sd90) begin
			t_full = raw;
			d      = {cfg.e90[ERROR_W-1], cfg.e90} - {cfg.e0[ERROR_W-1], cfg.e0};
			base   = cfg.e0;
		end else if (raw >= 11'sd90 && raw < 11'sd180) begin
			t_full = raw - 11'sd90;
			d      = {cfg.e180[ERROR_W-1], cfg.e180} - {cfg.e90[ERROR_W-1], cfg.e90};
			base   = cfg.e90;
		end else if (raw < 0 && raw > -11'sd90) begin
			t_full = -raw;
			d      = {cfg.e270[ERROR_W-1], cfg.e270} - {cfg.e0[ERROR_W-1], cfg.e0};
			base   = cfg.e0;
		end else if (raw <= -11'sd90 && raw > -11'sd180) begin
			t_full = -raw - 11'sd90;
			d      = {cfg.e180[ERROR_W-1], cfg.e180} - {cfg.e270[ERROR_W-1], cfg.e270};
			base   = cfg.e270;
		end
	end

	assign t     = t_full[6:0];
	assign t_ext = $signed({1'b0, t});
	assign prod  = PROD_W'(t_ext) * PROD_W'(d);

	// Stage register.
	always_ff @(posedge clk) begin
		if (load) begin
			s2.mode <= mode;
			s2.raw  <= raw;
			s2.prod <= prod;
			s2.base <= base;
		end
	end

endmodule

/* rtl/core/wacmt_angle.sv */
// Deviation by truncating division by 90, subtraction and wrap into (-180,180].
// Depends on wacmt_pkg.
module wacmt_angle
	import wacmt_pkg::*;
(
	input  logic      clk,
	input  logic      load,
	input  wacmt_s2_t s2,
	output wacmt_s3_t s3
);

	logic                      neg;
	logic [PROD_W-1:0]         prod_abs;
	logic [MAG_W-1:0]          mag;
	logic [2*MAG_W-1:0]        scaled;
	logic [8:0]                quot;
	logic signed [9:0]         quot_s;
	logic signed [9:0]         dev_w;
	logic signed [11:0]        diff;
	logic signed [11:0]        wrapped;

	// Sign and magnitude, so that the quotient truncates toward zero.
	assign neg      = s2.prod[PROD_W-1];
	assign prod_abs = neg ? PROD_W'(-s2.prod) : PROD_W'(s2.prod);
	assign mag      = prod_abs[MAG_W-1:0];

	// Reciprocal multiply for the division by 90.
	assign scaled = (2*MAG_W)'(mag) * (2*MAG_W)'(RECIP_90);
	assign quot   = scaled[RECIP_SHIFT+8:RECIP_SHIFT];
	assign quot_s = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
	assign dev_w  = quot_s + 10'(s2.base);

	// Subtract the deviation and fold back into a half turn either side.
	assign diff = 12'(s2.raw) - 12'(dev_w);

	always_comb begin
		if (diff > 12'sd540) begin
			wrapped = diff - 12'sd720;
		end else if (diff > 12'sd180) begin
			wrapped = diff - 12'sd360;
		end else if (diff <= -12'sd540) begin
			wrapped = diff + 12'sd720;
		end else if (diff <= -12'sd180) begin
			wrapped = diff + 12'sd360;
		end else begin
			wrapped = diff;
		end
	end

	// Stage register.
	always_ff @(posedge clk) begin
		if (load) begin
			s3.mode  <= s2.mode;
			s3.angle <= wrapped[ANGLE_W-1:0];
			s3.dev   <= dev_w[DEV_W-1:0];
		end
	end

endmodule

/* rtl/core/wacmt_track.sv */
// Peak tracking, movement figure, health check and the result register.
// Depends on wacmt_pkg.
module wacmt_track
	import wacmt_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  wacmt_s3_t                 s3,
	output logic signed [ANGLE_W-1:0] angle_q,
	output logic signed [DEV_W-1:0]   dev_q,
	output logic signed [MOVE_W-1:0]  move_out_q,
	output logic                      good_out_q,
	output logic signed [MOVE_W-1:0]  peak_stbd_q,
	output logic signed [MOVE_W-1:0]  peak_port_q
);

	logic signed [MOVE_W-1:0] move_now_q;
	logic signed [MOVE_W-1:0] move_before_q;
	logic                     last_good_q;

	logic signed [MOVE_W-1:0] stbd_dec;
	logic signed [MOVE_W-1:0] port_dec;
	logic signed [MOVE_W-1:0] a_ext;
	logic signed [MOVE_W-1:0] stbd_cand;
	logic signed [MOVE_W-1:0] port_cand;
	logic signed [MOVE_W-1:0] stbd_next;
	logic signed [MOVE_W-1:0] port_next;
	logic signed [MOVE_W-1:0] move_next;
	logic                     good_next;

	// Multiply by 0.999 with truncation toward zero; magnitudes stay under 1024.
	function automatic logic signed [MOVE_W-1:0] decay(input logic signed [MOVE_W-1:0] p);
		logic [MOVE_W-1:0] m;
		logic [MOVE_W-1:0] r;
		begin
			m = p[MOVE_W-1] ? MOVE_W'(-p) : MOVE_W'(p);
			if (m == '0) begin
				r = '0;
			end else if (m > MOVE_W'(1000)) begin
				r = m - MOVE_W'(2);
			end else begin
				r = m - MOVE_W'(1);
			end
			decay = p[MOVE_W-1] ? -$signed(r) : $signed(r);
		end
	endfunction

	assign stbd_dec = decay(peak_stbd_q);
	assign port_dec = decay(peak_port_q);
	assign a_ext    = MOVE_W'(s3.angle);

	// Angle >= 0 sets the starboard peak, < 0 the port; its mirror a turn away the other.
	always_comb begin
		if (!s3.angle[ANGLE_W-1]) begin
			stbd_cand = a_ext;
			port_cand = a_ext - 11'sd360;
		end else begin
			stbd_cand = a_ext + 11'sd360;
			port_cand = a_ext;
		end
		stbd_next = (stbd_dec < stbd_cand) ? stbd_cand : stbd_dec;
		port_next = (port_dec > port_cand) ? port_cand : port_dec;
		move_next = stbd_next - port_next - 11'sd360;
		good_next = (move_now_q != '0) || (move_before_q != '0);
	end

	// Tracking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_stbd_q   <= '0;
			peak_port_q   <= '0;
			move_now_q    <= '0;
			move_before_q <= '0;
			last_good_q   <= 1'b0;
		end else if (fire) begin
			if (s3.mode == MODE_ANGLE) begin
				peak_stbd_q <= stbd_next;
				peak_port_q <= port_next;
				move_now_q  <= move_next;
			end else begin
				last_good_q   <= good_next;
				move_before_q <= move_now_q;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (fire) begin
			if (s3.mode == MODE_ANGLE) begin
				angle_q    <= s3.angle;
				dev_q      <= s3.dev;
				move_out_q <= move_next;
				good_out_q <= last_good_q;
			end else begin
				angle_q    <= '0;
				dev_q      <= '0;
				move_out_q <= move_now_q;
				good_out_q <= good_next;
			end
		end
	end

endmodule

/* rtl/core/wing_angle_correct_and_motion_track_core.sv */
// Wing angle correction and motion tracking core, top level.
// Channels: s_axis carries one item per beat. tuser is the mode (0 angle sample,
// 1 health tick) and tdata[8:0] the signed raw bearing. m_axis returns one result
// beat per input beat: tdata holds, from bit 0 up, corrected angle (9), deviation
// (8), movement (11) and the data-good flag (1).
// Calibration is written through cfg_we/cfg_index/cfg_data: 0 offset, 1..4 the
// errors at 0, 90, 180 and 270 degrees. Write it only while no beat is in flight.
// The path has an input register, an interpolation stage, a division and wrap stage and
// the result register; one beat is taken every cycle unless back-pressure has filled
// every stage. The division by 90 is a reciprocal multiply.
// Reset clears the calibration registers, the peaks, the movement history and
// the health flag, and empties the pipeline.
// When the receiver holds m_axis_tready low, the result stays put and the stages
// behind it fill; s_axis_tready drops only once every stage holds a beat.
// Depends on wacmt_pkg, wacmt_interp, wacmt_angle and wacmt_track.
module wing_angle_correct_and_motion_track_core
	import wacmt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [8:0] bearing
	input  logic                  s_axis_tuser,   // [0] mode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [8:0] corrected_angle, [16:9] deviation,
	                                              // [27:17] movement, [28] data_good
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	wacmt_cfg_t cfg_q;

	logic                        v_s1;
	logic                        v_s2;
	logic                        v_s3;
	logic                        v_out_q;
	logic                        mode_s1;
	logic signed [BEARING_W-1:0] bearing_s1;
	wacmt_s2_t                   pay_s2;
	wacmt_s3_t                   pay_s3;

	logic rdy_out;
	logic rdy3;
	logic rdy2;
	logic rdy1;

	logic signed [ANGLE_W-1:0] angle_q;
	logic signed [DEV_W-1:0]   dev_q;
	logic signed [MOVE_W-1:0]  move_out_q;
	logic                      good_out_q;
	logic signed [MOVE_W-1:0]  peak_stbd_q;
	logic signed [MOVE_W-1:0]  peak_port_q;

	// Calibration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAL_OFFSET: cfg_q.offset <= cfg_data;
				REG_ERROR_0:    cfg_q.e0     <= cfg_data[ERROR_W-1:0];
				REG_ERROR_90:   cfg_q.e90    <= cfg_data[ERROR_W-1:0];
				REG_ERROR_180:  cfg_q.e180   <= cfg_data[ERROR_W-1:0];
				REG_ERROR_270:  cfg_q.e270   <= cfg_data[ERROR_W-1:0];
				default: ;
			endcase
		end
	end

	// Each stage moves on when the next one is empty or moving on itself.
	assign rdy_out       = !v_out_q || m_axis_tready;
	assign rdy3          = !v_s3 || rdy_out;
	assign rdy2          = !v_s2 || rdy3;
	assign rdy1          = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy_out) begin
				v_out_q <= v_s3;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (rdy1) begin
			mode_s1    <= s_axis_tuser;
			bearing_s1 <= s_axis_tdata[BEARING_W-1:0];
		end
	end

	wacmt_interp u_interp (
		.clk     (clk),
		.load    (rdy2),
		.mode    (mode_s1),
		.bearing (bearing_s1),
		.cfg     (cfg_q),
		.s2      (pay_s2)
	);

	wacmt_angle u_angle (
		.clk  (clk),
		.load (rdy3),
		.s2   (pay_s2),
		.s3   (pay_s3)
	);

	wacmt_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (v_s3 && rdy_out),
		.s3          (pay_s3),
		.angle_q     (angle_q),
		.dev_q       (dev_q),
		.move_out_q  (move_out_q),
		.good_out_q  (good_out_q),
		.peak_stbd_q (peak_stbd_q),
		.peak_port_q (peak_port_q)
	);

	// Result beat.
	assign m_axis_tvalid = v_out_q;
	assign m_axis_tdata  = {3'b000, good_out_q, move_out_q, dev_q, angle_q};

`ifndef SYNTHESIS
	// The starboard peak never goes negative and the port peak never positive.
	a_peak_signs: assert property (@(posedge clk) disable iff (!arst_n)
		!peak_stbd_q[MOVE_W-1] && (peak_port_q[MOVE_W-1] || peak_port_q == '0))
		else $error("movement peak on the wrong side of zero");

	// An angle leaving the wrap stage lies in the half-open half turn.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (pay_s3.angle > -9'sd180 && pay_s3.angle <= 9'sd180))
		else $error("corrected angle outside (-180,180]");

	// The input side stalls only when every stage behind it is occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v_s1 && v_s2 && v_s3 && v_out_q && !m_axis_tready))
		else $error("input stalled with a free stage");

	// A result that is not taken is still offered in the next cycle.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && m_axis_tvalid && !m_axis_tready) |=> (v_s3 && m_axis_tvalid))
		else $error("pipeline beat lost under back-pressure");
`endif

endmodule

/* sim/tb_wing_angle_correct_and_motion_track_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for wing_angle_correct_and_motion_track_core: angle samples and
// health ticks are streamed in with random idling on both sides and every result beat is
// checked against an in-house prediction. Depends on wacmt_pkg and the core RTL.
module tb_wing_angle_correct_and_motion_track_core;
	import wacmt_pkg::*;

	// Result beat layout, from bit 0 up
	localparam int DEV_LO   = ANGLE_W;
	localparam int MOVE_LO  = ANGLE_W + DEV_W;
	localparam int GOOD_BIT = ANGLE_W + DEV_W + MOVE_W;

	localparam int PHASES         = 6;
	localparam int PHASE_BEATS    = 125;
	localparam int SETTLE_CYCLES  = 4;
	localparam int HOLD_AFTER     = 330;
	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 2000;

	// First index past the calibration registers; writes there must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

	typedef enum logic [1:0] {OP_BEAT, OP_WRITE, OP_PAUSE} op_kind_t;

	typedef struct {
		op_kind_t                    kind;
		logic                        mode;
		logic signed [BEARING_W-1:0] bearing;
		logic [CFG_IDX_W-1:0]        index;
		logic [CFG_DATA_W-1:0]       value;
	} stim_op_t;

	typedef struct packed {
		logic                      good;
		logic signed [MOVE_W-1:0]  movement;
		logic signed [DEV_W-1:0]   dev;
		logic signed [ANGLE_W-1:0] angle;
	} wing_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata = '0;   // [8:0] bearing
	logic                  s_axis_tuser = 1'b0; // [0] mode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;        // [8:0] angle, [16:9] deviation,
	                                            // [27:17] movement, [28] data_good
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor copy of the calibration and the tracking state
	logic signed [OFFSET_W-1:0] cal_offset = '0;
	logic signed [ERROR_W-1:0]  cal_e0 = '0;
	logic signed [ERROR_W-1:0]  cal_e90 = '0;
	logic signed [ERROR_W-1:0]  cal_e180 = '0;
	logic signed [ERROR_W-1:0]  cal_e270 = '0;
	int   peak_stbd = 0;
	int   peak_port = 0;
	int   move_now = 0;
	int   move_prev = 0;
	logic health_ok = 1'b0;

	stim_op_t     pending_ops[$];
	wing_result_t awaited_results[$];

	int   mismatches = 0;
	int   beats_sent = 0;
	int   results_seen = 0;
	int   src_gap = 0;
	int   src_steady = 0;
	int   quiet_cycles = 0;
	int   sink_gap = 0;
	int   sink_steady = 0;
	logic stim_done = 1'b0;

	wing_angle_correct_and_motion_track_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int rand_between(input int lo, input int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// Idle length: mostly none or short, now and then a long one.
	function automatic int idle_len();
		int r;
		r = rand_between(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return rand_between(1, 3);
		if (r < 97)
			return rand_between(4, 12);
		return rand_between(25, 70);
	endfunction

	// Linear interpolation between the four calibration errors; zero outside (-180,180).
	function automatic int deviation_for(input int x);
		int e0, e90, e180, e270;
		e0   = cal_e0;
		e90  = cal_e90;
		e180 = cal_e180;
		e270 = cal_e270;
		if (x >= 0 && x < 90)
			return (x * (e90 - e0)) / 90 + e0;
		if (x >= 90 && x < 180)
			return ((x - 90) * (e180 - e90)) / 90 + e90;
		if (x < 0 && x > -90)
			return (x * (e270 - e0)) / -90 + e0;
		if (x <= -90 && x > -180)
			return ((x + 90) * (e180 - e270)) / -90 + e270;
		return 0;
	endfunction

	// Work out the result of one accepted beat and queue it.
	task automatic predict_wing_result(input logic mode,
	                                   input logic signed [BEARING_W-1:0] bearing);
		int raw, dev, ang;
		wing_result_t r;
		ang = 0;
		dev = 0;
		if (mode == MODE_ANGLE) begin
			raw = int'(bearing) + int'(cal_offset);
			dev = deviation_for(raw);
			ang = (raw - dev) % 360;
			if (ang < 0)
				ang += 360;
			if (ang > 180)
				ang -= 360;
			peak_port = (peak_port * 999) / 1000;
			peak_stbd = (peak_stbd * 999) / 1000;
			if (ang >= 0) begin
				if (peak_stbd < ang)
					peak_stbd = ang;
				if (peak_port > ang - 360)
					peak_port = ang - 360;
			end else begin
				if (peak_port > ang)
					peak_port = ang;
				if (peak_stbd < ang + 360)
					peak_stbd = ang + 360;
			end
			move_now = peak_stbd - peak_port - 360;
		end else begin
			health_ok = !(move_now == 0 && move_prev == 0);
			move_prev = move_now;
		end
		r.angle    = ANGLE_W'(ang);
		r.dev      = DEV_W'(dev);
		r.movement = MOVE_W'(move_now);
		r.good     = health_ok;
		awaited_results.push_back(r);
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t: %s", $realtime, msg);
	endtask

	task automatic add_beat(input logic mode, input int bearing);
		stim_op_t op;
		op.kind    = OP_BEAT;
		op.mode    = mode;
		op.bearing = BEARING_W'(bearing);
		op.index   = '0;
		op.value   = '0;
		pending_ops.push_back(op);
	endtask

	task automatic add_write(input logic [CFG_IDX_W-1:0] index, input int value);
		stim_op_t op;
		op.kind    = OP_WRITE;
		op.mode    = MODE_ANGLE;
		op.bearing = '0;
		op.index   = index;
		op.value   = CFG_DATA_W'(value);
		pending_ops.push_back(op);
	endtask

	// Bearing for a random sample: mostly aimed so that the raw sum lands inside the
	// interpolation range or next to a segment edge, the rest anywhere in the field.
	function automatic int pick_bearing(input int off);
		int r, aim;
		r = rand_between(0, 99);
		if (r < 15)
			return rand_between(-256, 255);
		if (r < 30)
			return rand_between(-180, 180);
		if (r < 55)
			aim = -180 + 90 * rand_between(0, 4) + rand_between(-1, 1);
		else
			aim = rand_between(-179, 179);
		aim = aim - off;
		if (aim < -256 || aim > 255)
			aim = rand_between(-180, 180);
		return aim;
	endfunction

	// Sender: takes operations from the pending queue, one per cycle at most.
	// Calibration writes and pauses wait until every result has come back.
	always @(posedge clk or negedge arst_n) begin : source
		stim_op_t             op;
		logic                 next_valid;
		logic                 next_we;
		logic [S_TDATA_W-1:0] word;
		int                   in_flight;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
			cfg_we        <= 1'b0;
			cfg_index     <= '0;
			cfg_data      <= '0;
			stim_done     <= 1'b0;
		end else begin
			next_valid = s_axis_tvalid;
			next_we    = 1'b0;
			if (s_axis_tvalid && s_axis_tready) begin
				predict_wing_result(s_axis_tuser, s_axis_tdata[BEARING_W-1:0]);
				beats_sent++;
				next_valid = 1'b0;
				if (src_steady > 0) begin
					src_steady--;
					src_gap = 0;
				end else begin
					src_gap = idle_len();
					if (rand_between(0, 39) == 0)
						src_steady = rand_between(20, 60);
				end
			end
			in_flight = beats_sent - results_seen;
			if (!next_valid && in_flight == 0)
				quiet_cycles++;
			else
				quiet_cycles = 0;

			if (!next_valid && src_gap > 0) begin
				src_gap--;
			end else if (!next_valid && pending_ops.size() != 0) begin
				op = pending_ops[0];
				case (op.kind)
				OP_BEAT: begin
					void'(pending_ops.pop_front());
					word = '0;
					word[BEARING_W-1:0] = op.bearing;
					s_axis_tdata <= word;
					s_axis_tuser <= op.mode;
					next_valid = 1'b1;
				end
				OP_WRITE: begin
					if (quiet_cycles >= SETTLE_CYCLES) begin
						void'(pending_ops.pop_front());
						cfg_index <= op.index;
						cfg_data  <= op.value;
						next_we = 1'b1;
						case (op.index)
						REG_CAL_OFFSET: cal_offset = op.value;
						REG_ERROR_0:    cal_e0 = op.value[ERROR_W-1:0];
						REG_ERROR_90:   cal_e90 = op.value[ERROR_W-1:0];
						REG_ERROR_180:  cal_e180 = op.value[ERROR_W-1:0];
						REG_ERROR_270:  cal_e270 = op.value[ERROR_W-1:0];
						default: ;
						endcase
					end
				end
				default: begin
					if (in_flight == 0)
						void'(pending_ops.pop_front());
				end
				endcase
			end
			s_axis_tvalid <= next_valid;
			cfg_we        <= next_we;
			stim_done     <= pending_ops.size() == 0 && !next_valid && in_flight == 0;
		end
	end

	// Receiver: random stalls, plus one long hold-off so that the pipeline fills up.
	always @(posedge clk or negedge arst_n) begin : sink
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (results_seen + 1 == HOLD_AFTER) begin
					sink_gap = HOLD_CYCLES;
				end else if (sink_steady > 0) begin
					sink_steady--;
					sink_gap = 0;
				end else begin
					sink_gap = idle_len();
					if (rand_between(0, 39) == 0)
						sink_steady = rand_between(20, 60);
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Monitor: every result beat is checked against the oldest expectation.
	always @(posedge clk) begin : monitor
		wing_result_t         want;
		logic [M_TDATA_W-1:0] got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			results_seen <= results_seen + 1;
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("result beat %0d (%h) with nothing expected",
					results_seen, got));
			end else begin
				want = awaited_results.pop_front();
				if (got[DEV_LO-1:0] !== want.angle)
					report_mismatch($sformatf("beat %0d angle: got %0d, expected %0d",
						results_seen, $signed(got[DEV_LO-1:0]), want.angle));
				if (got[MOVE_LO-1:DEV_LO] !== want.dev)
					report_mismatch($sformatf("beat %0d deviation: got %0d, expected %0d",
						results_seen, $signed(got[MOVE_LO-1:DEV_LO]), want.dev));
				if (got[GOOD_BIT-1:MOVE_LO] !== want.movement)
					report_mismatch($sformatf("beat %0d movement: got %0d, expected %0d",
						results_seen, $signed(got[GOOD_BIT-1:MOVE_LO]), want.movement));
				if (got[GOOD_BIT] !== want.good)
					report_mismatch($sformatf("beat %0d data_good: got %b, expected %b",
						results_seen, got[GOOD_BIT], want.good));
				if (got[M_TDATA_W-1:GOOD_BIT+1] !== '0)
					report_mismatch($sformatf("beat %0d padding bits not zero: %h",
						results_seen, got));
			end
		end
	end

	// Watchdog: ends the run when nothing has moved for too long.
	initial begin : watchdog
		int still;
		still = 0;
		while (still < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				still = 0;
			else
				still++;
		end
		$display("tb_wing_angle_correct_and_motion_track_core NOT OK");
		$finish;
	end

	initial begin : stimulus
		int ph, n, off, e0, e90, e180, e270;

		// Out of reset: a tick with no movement, a sample that keeps movement at zero,
		// a second tick that must report bad data, then real movement and a good tick.
		add_beat(MODE_HEALTH, rand_between(-256, 255));
		add_beat(MODE_ANGLE, 0);
		add_beat(MODE_HEALTH, rand_between(-256, 255));
		add_beat(MODE_ANGLE, 90);
		add_beat(MODE_HEALTH, rand_between(-256, 255));

		// Uneven errors, then every interpolation segment, its edges and the field limits.
		add_write(REG_CAL_OFFSET, 0);
		add_write(REG_ERROR_0, 5);
		add_write(REG_ERROR_90, -20);
		add_write(REG_ERROR_180, 30);
		add_write(REG_ERROR_270, -40);
		add_beat(MODE_ANGLE, 0);
		add_beat(MODE_ANGLE, 45);
		add_beat(MODE_ANGLE, 89);
		add_beat(MODE_ANGLE, 90);
		add_beat(MODE_ANGLE, 135);
		add_beat(MODE_ANGLE, 179);
		add_beat(MODE_ANGLE, 180);
		add_beat(MODE_ANGLE, -1);
		add_beat(MODE_ANGLE, -45);
		add_beat(MODE_ANGLE, -89);
		add_beat(MODE_ANGLE, -90);
		add_beat(MODE_ANGLE, -135);
		add_beat(MODE_ANGLE, -179);
		add_beat(MODE_ANGLE, -180);
		add_beat(MODE_ANGLE, 255);
		add_beat(MODE_ANGLE, -256);
		add_beat(MODE_HEALTH, 0);

		// Random phases, each under its own calibration; the extremes come in between.
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
			0: begin
				off  = rand_between(-180, 180);
				e0   = rand_between(-90, 90);
				e90  = rand_between(-90, 90);
				e180 = rand_between(-90, 90);
				e270 = rand_between(-90, 90);
			end
			1: begin
				off = 180;  e0 = 90;  e90 = -90; e180 = 90;  e270 = -90;
			end
			2: begin
				off = -180; e0 = -90; e90 = 90;  e180 = -90; e270 = 90;
			end
			3: begin
				off = 255;  e0 = 127; e90 = -128; e180 = 127; e270 = -128;
			end
			4: begin
				off = -256; e0 = -128; e90 = 127; e180 = -128; e270 = 127;
			end
			default: begin
				off  = rand_between(-256, 255);
				e0   = rand_between(-128, 127);
				e90  = rand_between(-128, 127);
				e180 = rand_between(-128, 127);
				e270 = rand_between(-128, 127);
			end
			endcase
			add_write(REG_CAL_OFFSET, off);
			// In the last phase the unused top data bit of the error writes toggles too.
			if (ph == PHASES - 1) begin
				add_write(REG_ERROR_0, e0 ^ (rand_between(0, 1) << ERROR_W));
				add_write(REG_ERROR_90, e90 ^ (rand_between(0, 1) << ERROR_W));
				add_write(REG_ERROR_180, e180 ^ (rand_between(0, 1) << ERROR_W));
				add_write(REG_ERROR_270, e270 ^ (rand_between(0, 1) << ERROR_W));
				add_write(REG_UNUSED + CFG_IDX_W'(rand_between(0, 2)), rand_between(-256, 255));
			end else begin
				add_write(REG_ERROR_0, e0);
				add_write(REG_ERROR_90, e90);
				add_write(REG_ERROR_180, e180);
				add_write(REG_ERROR_270, e270);
			end
			for (n = 0; n < PHASE_BEATS; n++) begin
				// Once, the sender stops until every result is back.
				if (ph == 4 && n == PHASE_BEATS / 2) begin
					pending_ops.push_back('{OP_PAUSE, MODE_ANGLE, '0, '0, '0});
				end
				if (rand_between(0, 7) == 0)
					add_beat(MODE_HEALTH, rand_between(-256, 255));
				else
					add_beat(MODE_ANGLE, pick_bearing(off));
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do
			@(posedge clk);
		while (!stim_done);
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		if (awaited_results.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				awaited_results.size()));
		if (mismatches == 0)
			$display("tb_wing_angle_correct_and_motion_track_core OK");
		else
			$display("tb_wing_angle_correct_and_motion_track_core NOT OK");
		$finish;
	end

endmodule

/* files.f */
rtl/core/wacmt_pkg.sv
rtl/core/wacmt_interp.sv
rtl/core/wacmt_angle.sv
rtl/core/wacmt_track.sv
rtl/core/wing_angle_correct_and_motion_track_core.sv
sim/tb_wing_angle_correct_and_motion_track_core.sv
